// File: hdl/utf8_lenient_char_counter_macros.svh
// Assertion macros shared by the counter's RTL files.
`ifndef UTF8_LENIENT_CHAR_COUNTER_MACROS_SVH
`define UTF8_LENIENT_CHAR_COUNTER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked while out of reset.
`define ULCC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ulcc assertion failed");
// Checked at every edge, reset included.
`define ULCC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ulcc assertion failed");
`else
`define ULCC_ASSERT(lbl, clk, rst_n, prop)
`define ULCC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: hdl/ulcc_pkg.sv
package ulcc_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CMP_W      = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_COUNT_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CHAR_LIMIT = CFG_IDX_W'(1);

    localparam logic [1:0] MODE_UNTIL_ZERO = 2'd0;
    localparam logic [1:0] MODE_UNTIL_END  = 2'd1;
    localparam logic [1:0] MODE_BYTE_SPAN  = 2'd2;

    typedef logic [COUNT_BITS-1:0] t_cnt;
    typedef logic [2:0]            t_len;

    // What the front found in one byte's window: up to four characters,
    // running byte sums of their lengths, and how the step ends.
    typedef struct packed {
        t_len           nchar;
        t_len [3:0]     psum;
        logic           zero_stop;
        logic           flush;
    } t_rec;

    function automatic t_cnt sat_add(input t_cnt a, input t_len b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + (COUNT_BITS + 1)'(b);
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

    function automatic logic lim_eq(input t_cnt c, input logic [15:0] lim);
        return CMP_W'(c) == CMP_W'(lim);
    endfunction

    function automatic logic [15:0] out_val(input t_cnt c);
        return (CMP_W'(c) > CMP_W'(16'hFFFF)) ? 16'hFFFF : 16'(c);
    endfunction

endpackage

// File: hdl/ulcc_front.sv
`include "utf8_lenient_char_counter_macros.svh"

module ulcc_front
    import ulcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_stop_zero,
    output t_rec       o_rec
);

    logic [7:0] r_pend [3];
    logic [1:0] r_fill;
    logic [7:0] n_pend [3];
    logic [1:0] n_fill;

    logic [7:0] q [4];

    always_comb begin
        logic [2:0] n;
        logic [2:0] pos;
        logic [2:0] len;
        logic [2:0] need;
        logic [2:0] idx;
        logic [2:0] nch;
        logic [2:0] sum;
        logic [7:0] b;
        logic       done;
        logic       hold;
        logic       brk;

        for (int i = 0; i < 3; i++) begin
            if (2'(i) < r_fill) begin
                q[i] = r_pend[i];
            end else if (2'(i) == r_fill) begin
                q[i] = i_data_byte;
            end else begin
                q[i] = 8'h00;
            end
        end
        q[3] = (r_fill == 2'd3) ? i_data_byte : 8'h00;

        n     = {1'b0, r_fill} + 3'd1;
        pos   = 3'd0;
        nch   = 3'd0;
        sum   = 3'd0;
        len   = 3'd1;
        need  = 3'd1;
        idx   = 3'd0;
        b     = 8'h00;
        brk   = 1'b0;
        done  = 1'b0;
        hold  = 1'b0;
        o_rec = '0;
        o_rec.flush = i_last_byte;

        for (int it = 0; it < 4; it++) begin
            if (!done && pos < n) begin
                b = q[pos[1:0]];
                if (i_stop_zero && b == 8'h00) begin
                    o_rec.zero_stop = 1'b1;
                    done = 1'b1;
                end else begin
                    len = 3'd1;
                    if (b[7:6] == 2'b11) begin
                        need = b[5] ? (b[4] ? 3'd4 : 3'd3) : 3'd2;
                        len  = need;
                        brk  = 1'b0;
                        for (int k = 1; k < 4; k++) begin
                            if (!brk && 3'(k) < need) begin
                                idx = pos + 3'(k);
                                if (idx >= n) begin
                                    // sequence runs past the window
                                    hold = !i_last_byte;
                                    len  = 3'd1;
                                    brk  = 1'b1;
                                end else if (!q[idx[1:0]][7]) begin
                                    len = 3'd1;
                                    brk = 1'b1;
                                end
                            end
                        end
                    end
                    if (hold) begin
                        done = 1'b1;
                    end else begin
                        sum = sum + len;
                        o_rec.psum[nch[1:0]] = sum;
                        nch = nch + 3'd1;
                        pos = pos + len;
                    end
                end
            end
        end
        o_rec.nchar = nch;

        for (int i = 0; i < 3; i++) begin
            idx = pos + 3'(i);
            n_pend[i] = (hold && idx < n) ? q[idx[1:0]] : 8'h00;
        end
        n_fill = hold ? 2'(n - pos) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
        end else if (i_accept) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pend <= n_pend;
        end
    end

    // a held window always opens with a lead byte
    `ULCC_ASSERT(a_pend_lead, i_clk, i_rst_n, (r_fill != 2'd0) |-> (r_pend[0][7:6] == 2'b11))
    `ULCC_ASSERT(a_nchar_fit, i_clk, i_rst_n, i_accept |-> (o_rec.nchar <= ({1'b0, r_fill} + 3'd1)))

endmodule

// File: hdl/ulcc_queue.sv
`include "utf8_lenient_char_counter_macros.svh"

module ulcc_queue
    import ulcc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_rec i_wr_data,
    output logic o_full,
    input  logic i_rd,
    output logic o_valid,
    output t_rec o_rd_data
);

    t_rec               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    logic wr_en;
    logic rd_en;

    assign o_full    = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && o_valid;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (rd_en) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    `ULCC_ASSERT(a_q_grow, i_clk, i_rst_n, (wr_en && !rd_en) |=> (r_count == $past(r_count) + Q_CNT_W'(1)))
    `ULCC_ASSERT(a_q_bound, i_clk, i_rst_n, r_count <= Q_CNT_W'(Q_DEPTH))

endmodule

// File: hdl/ulcc_back.sv
`include "utf8_lenient_char_counter_macros.svh"

module ulcc_back
    import ulcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rec_valid,
    input  t_rec        i_rec,
    output logic        o_rec_take,
    input  logic        i_limited,
    input  logic [15:0] i_char_limit,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [15:0] o_count_value,
    output logic        o_ended_early
);

    t_cnt        r_char_total;
    t_cnt        r_byte_total;
    logic        r_answered;
    logic        r_out_valid;
    logic [15:0] r_value;
    logic        r_early;

    t_cnt        n_char_total;
    t_cnt        n_byte_total;
    logic        n_answered;

    t_cnt        ct [5];
    t_cnt        bt [5];
    logic        hit;
    t_cnt        hit_bt;
    logic        emit;
    logic [15:0] emit_val;
    logic        emit_early;

    assign o_rec_take = i_rec_valid && (!r_out_valid || i_pop);

    always_comb begin
        ct[0] = r_char_total;
        bt[0] = r_byte_total;
        for (int j = 1; j < 5; j++) begin
            ct[j] = sat_add(r_char_total, 3'(j));
            bt[j] = sat_add(r_byte_total, i_rec.psum[j-1]);
        end

        // earliest character boundary at which the limit is met
        hit    = 1'b0;
        hit_bt = '0;
        for (int j = 4; j >= 0; j--) begin
            if (i_limited && 3'(j) <= i_rec.nchar && lim_eq(ct[j], i_char_limit)) begin
                hit    = 1'b1;
                hit_bt = bt[j];
            end
        end

        emit         = 1'b0;
        emit_val     = 16'h0000;
        emit_early   = 1'b0;
        n_char_total = r_char_total;
        n_byte_total = r_byte_total;
        n_answered   = r_answered;

        if (o_rec_take) begin
            if (!r_answered) begin
                priority if (hit) begin
                    emit     = 1'b1;
                    emit_val = out_val(hit_bt);
                end else begin
                    n_char_total = ct[i_rec.nchar];
                    n_byte_total = bt[i_rec.nchar];
                    if (i_rec.zero_stop || i_rec.flush) begin
                        emit       = 1'b1;
                        emit_val   = out_val(i_limited ? bt[i_rec.nchar] : ct[i_rec.nchar]);
                        emit_early = i_limited;
                    end
                end
                if (emit) begin
                    n_answered = 1'b1;
                end
            end
            if (i_rec.flush) begin
                n_char_total = '0;
                n_byte_total = '0;
                n_answered   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_total <= '0;
            r_byte_total <= '0;
            r_answered   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_char_total <= n_char_total;
            r_byte_total <= n_byte_total;
            r_answered   <= n_answered;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_value <= emit_val;
            r_early <= emit_early;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_count_value = r_value;
    assign o_ended_early = r_early;

    `ULCC_ASSERT(a_answer_set, i_clk, i_rst_n, (emit && !i_rec.flush) |=> r_answered)
    `ULCC_ASSERT(a_string_clear, i_clk, i_rst_n, (o_rec_take && i_rec.flush) |=> (!r_answered && r_char_total == '0 && r_byte_total == '0))

endmodule

// File: hdl/utf8_lenient_char_counter.sv
// Lenient UTF-8 character counter. Bytes go in through push/full at one per
// cycle while full is low; last_byte closes a string and each string gives
// exactly one result on the empty/pop side. A byte passes the front, which
// splits the window into characters combinationally, the two-entry queue,
// and the back, which updates the saturating counters and loads the result
// register. The rate is set by the back stage taking one front record per
// cycle unless an unpopped result holds it; the queue and the result
// register let either side stall without dropping a record. count_mode and
// char_limit are written through the cfg channel, which is always ready,
// and must only change between strings. No clearing pass after reset.
module utf8_lenient_char_counter
    import ulcc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output logic                 empty,
    input  logic                 pop,
    output logic [15:0]          o_count_value,
    output logic                 o_ended_early,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    logic [1:0]  r_count_mode;
    logic [15:0] r_char_limit;

    logic accept;
    logic stop_zero;
    logic limited;
    t_rec front_rec;
    t_rec q_rec;
    logic q_valid;
    logic q_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_mode <= MODE_UNTIL_ZERO;
            r_char_limit <= 16'h0000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_COUNT_MODE) begin
                r_count_mode <= i_cfg_data[1:0];
            end else if (i_cfg_index == REG_CHAR_LIMIT) begin
                r_char_limit <= i_cfg_data;
            end
        end
    end

    // unused mode code counts to the end like MODE_UNTIL_END
    assign stop_zero = (r_count_mode == MODE_UNTIL_ZERO) || (r_count_mode == MODE_BYTE_SPAN);
    assign limited   = (r_count_mode == MODE_BYTE_SPAN);
    assign accept    = push && !full;

    ulcc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_stop_zero (stop_zero),
        .o_rec       (front_rec)
    );

    ulcc_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (accept),
        .i_wr_data (front_rec),
        .o_full    (full),
        .i_rd      (q_take),
        .o_valid   (q_valid),
        .o_rd_data (q_rec)
    );

    ulcc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rec_valid   (q_valid),
        .i_rec         (q_rec),
        .o_rec_take    (q_take),
        .i_limited     (limited),
        .i_char_limit  (r_char_limit),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_count_value (o_count_value),
        .o_ended_early (o_ended_early)
    );

endmodule
